/* src/new_reno_congestion_window_defines.svh */
// Assertion macros shared by the New Reno congestion window block.
// Included by the top level; expects clock and reset in the including scope.
`ifndef NEW_RENO_CONGESTION_WINDOW_DEFINES_SVH
`define NEW_RENO_CONGESTION_WINDOW_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRCW_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NRCW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/nrcw_pkg.sv */
// Shared types and constants of the New Reno congestion window block.
// Used by the controller, the datapath and the divider; depends on nothing.
package nrcw_pkg;

   localparam int DIV_W = 96;
   localparam logic [61:0] M62 = {62{1'b1}};

   typedef enum logic [2:0] {
      OP_ACK      = 3'd0,
      OP_ECN      = 3'd1,
      OP_REPEAT   = 3'd2,
      OP_TIMEOUT  = 3'd3,
      OP_SPURIOUS = 3'd4,
      OP_RESET    = 3'd5,
      OP_SEED     = 3'd6,
      OP_IGNORED  = 3'd7
   } opcode_type;

   localparam logic [2:0] REG_INITIAL  = 3'd0;
   localparam logic [2:0] REG_MINIMUM  = 3'd1;
   localparam logic [2:0] REG_SEGMENT  = 3'd2;
   localparam logic [2:0] REG_INTERVAL = 3'd3;
   localparam logic [2:0] REG_MULTIPATH = 3'd4;

   typedef enum logic [2:0] {
      MUL_BYTES_SEG,
      MUL_R_DL,
      MUL_R_DH,
      MUL_IVL_WL,
      MUL_IVL_WH
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_DELTA,
      ACC_NUM_LO,
      ACC_NUM_HI,
      ACC_DEN_LO,
      ACC_DEN_HI
   } acc_sel_type;

   typedef enum logic {
      DIV_MOD,
      DIV_QUO
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      logic        eval;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_sel_type acc_sel;
      logic        div_start;
      div_sel_type div_sel;
      logic        set_residue;
      logic        apply_avoid;
      logic        load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic long_ack;
      logic div_busy;
   } dp_status_type;

endpackage

/* src/nrcw_divider.sv */
// Restoring divider, one quotient bit per cycle, for the avoidance update.
// Depends on nrcw_pkg for the operand width.
module nrcw_divider import nrcw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             busy,
   output logic [DIV_W-1:0] quo,
   output logic [DIV_W-1:0] rem
);

   localparam int CW = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff, quo_ff, den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic [DIV_W-1:0] shift_in;
   logic             ge_in;

   assign shift_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
   assign ge_in    = shift_in >= den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(DIV_W - 1);
         rem_ff  <= '0;
         quo_ff  <= num;
         den_ff  <= den;
      end else if (busy_ff) begin
         rem_ff <= ge_in ? shift_in - den_ff : shift_in;
         quo_ff <= {quo_ff[DIV_W-2:0], ge_in};
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

/* src/nrcw_datapath.sv */
// Datapath: configuration registers, window state, event update logic,
// multiplier, accumulators and result registers. Depends on nrcw_pkg and nrcw_divider.
module nrcw_datapath import nrcw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          cfg_we,
   input  logic [2:0]    cfg_index,
   input  logic [31:0]   cfg_data,
   output logic [31:0]   cfg_rdata,
   input  logic [2:0]    req_opcode,
   input  logic [31:0]   req_byte_count,
   input  logic [62:0]   req_now_time,
   input  logic [31:0]   req_smoothed_rtt,
   input  logic [62:0]   req_next_send_sequence,
   input  logic [62:0]   req_highest_acked_sequence,
   input  logic [62:0]   req_acked_send_time,
   input  logic          req_history_empty,
   output logic [61:0]   rsp_window,
   output logic [61:0]   rsp_threshold,
   output logic          rsp_mode,
   output logic          rsp_entered_recovery
);

   logic [31:0] init_ff, minw_ff, ivl_ff;
   logic [15:0] seg_ff;
   logic        mp_ff;

   opcode_type  op_ff;
   logic [31:0] bytes_ff, srtt_ff;
   logic [62:0] now_ff, next_ff, aseq_ff, atime_ff;
   logic        hist_ff;

   logic [61:0] cwnd_ff, ss_ff, resid_ff;
   logic        inf_ff, avoid_ff, entered_ff;
   logic [62:0] rtime_ff, rseq_ff;

   logic [63:0]      prod_ff;
   logic [62:0]      delta_ff;
   logic [DIV_W-1:0] num_ff, den_ff;

   logic [61:0] rsp_window_ff, rsp_threshold_ff;
   logic        rsp_mode_ff, rsp_entered_ff;

   // Next state from the combinational event update.
   logic [61:0] cwnd_in, ss_in, resid_in;
   logic        inf_in, avoid_in, entered_in;
   logic [62:0] rtime_in, rseq_in;

   logic [62:0] elapsed, srtt63, dbl, sum_ss;
   logic [61:0] half, minw62, ss_loss, dbl_sat, ss_sum_sat;
   logic        past, fire_loss;

   logic [61:0] win;
   logic [31:0] ivl1, rmin, mul_a, mul_b;
   logic [64:0] qsum;
   logic [61:0] avoid_cwnd;

   logic [DIV_W-1:0] div_num, div_den, div_quo, div_rem;
   logic             div_busy;

   assign elapsed = now_ff - rtime_ff;
   assign srtt63  = {31'b0, srtt_ff};
   assign past    = mp_ff ? (rtime_ff <= atime_ff) : (rseq_ff <= aseq_ff);
   assign half    = {1'b0, cwnd_ff[61:1]};
   assign minw62  = {30'b0, minw_ff};
   assign ss_loss = (half < minw62) ? minw62 : half;
   assign dbl     = {ss_ff, 1'b0};
   assign dbl_sat = (dbl > {1'b0, M62}) ? M62 : dbl[61:0];
   assign sum_ss  = {1'b0, cwnd_ff} + {31'b0, bytes_ff};
   assign ss_sum_sat = (sum_ss > {1'b0, M62}) ? M62 : sum_ss[61:0];
   assign fire_loss  = (elapsed > srtt63) || past;

   always_comb begin
      cwnd_in    = cwnd_ff;
      ss_in      = ss_ff;
      resid_in   = resid_ff;
      inf_in     = inf_ff;
      avoid_in   = avoid_ff;
      entered_in = 1'b0;
      rtime_in   = rtime_ff;
      rseq_in    = rseq_ff;
      case (op_ff)
         OP_ACK: begin
            // Only slow-start acks reach this path; avoidance acks are iterative.
            if (!avoid_ff) begin
               cwnd_in = ss_sum_sat;
               if (!inf_ff && ss_sum_sat >= ss_ff) begin
                  avoid_in = 1'b1;
               end
            end
         end
         OP_ECN, OP_REPEAT, OP_TIMEOUT: begin
            if (fire_loss && !(avoid_ff && hist_ff)) begin
               entered_in = 1'b1;
               ss_in      = ss_loss;
               inf_in     = 1'b0;
               if (op_ff == OP_TIMEOUT) begin
                  cwnd_in  = minw62;
                  avoid_in = 1'b0;
               end else begin
                  cwnd_in  = ss_loss;
                  avoid_in = 1'b1;
               end
               rtime_in = now_ff;
               rseq_in  = next_ff;
               resid_in = '0;
            end
         end
         OP_SPURIOUS: begin
            if (elapsed < srtt63 && !past && !inf_ff && cwnd_ff < dbl_sat) begin
               cwnd_in  = dbl_sat;
               avoid_in = 1'b1;
            end
         end
         OP_RESET: begin
            cwnd_in  = {30'b0, init_ff};
            ss_in    = '0;
            inf_in   = 1'b1;
            avoid_in = 1'b0;
            rtime_in = '0;
            rseq_in  = '0;
            resid_in = '0;
         end
         OP_SEED: begin
            if (!avoid_ff && inf_ff && {30'b0, bytes_ff} > cwnd_ff) begin
               cwnd_in  = {30'b0, bytes_ff};
               ss_in    = {30'b0, bytes_ff};
               inf_in   = 1'b0;
               avoid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Avoidance operands; zero window and zero interval are read as one.
   assign win  = (cwnd_ff == '0) ? 62'd1 : cwnd_ff;
   assign ivl1 = (ivl_ff == '0) ? 32'd1 : ivl_ff;
   assign rmin = (srtt_ff < ivl_ff) ? srtt_ff : ivl_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_BYTES_SEG: begin mul_a = bytes_ff; mul_b = {16'b0, seg_ff};           end
         MUL_R_DL:      begin mul_a = rmin;     mul_b = delta_ff[31:0];            end
         MUL_R_DH:      begin mul_a = rmin;     mul_b = {1'b0, delta_ff[62:32]};   end
         MUL_IVL_WL:    begin mul_a = ivl1;     mul_b = win[31:0];                 end
         MUL_IVL_WH:    begin mul_a = ivl1;     mul_b = {2'b0, win[61:32]};        end
         default:       begin mul_a = '0;       mul_b = '0;                        end
      endcase
   end

   assign div_num = (cmd.div_sel == DIV_MOD) ? {33'b0, delta_ff} : num_ff;
   assign div_den = (cmd.div_sel == DIV_MOD) ? {34'b0, win} : den_ff;

   nrcw_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign qsum = {3'b0, cwnd_ff} + {1'b0, div_quo[63:0]};
   assign avoid_cwnd = (div_quo[DIV_W-1:64] != '0 || qsum > {3'b0, M62}) ? M62 : qsum[61:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= 32'd15360;
         minw_ff    <= 32'd3072;
         seg_ff     <= 16'd1440;
         ivl_ff     <= 32'd50000;
         mp_ff      <= 1'b0;
         cwnd_ff    <= 62'd15360;
         ss_ff      <= '0;
         inf_ff     <= 1'b1;
         avoid_ff   <= 1'b0;
         rtime_ff   <= '0;
         rseq_ff    <= '0;
         resid_ff   <= '0;
         entered_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            case (cfg_index)
               REG_INITIAL:   init_ff <= cfg_data;
               REG_MINIMUM:   minw_ff <= cfg_data;
               REG_SEGMENT:   seg_ff  <= cfg_data[15:0];
               REG_INTERVAL:  ivl_ff  <= cfg_data;
               REG_MULTIPATH: mp_ff   <= cfg_data[0];
               default: begin
               end
            endcase
         end
         if (cmd.capture) begin
            entered_ff <= 1'b0;
         end
         if (cmd.eval) begin
            cwnd_ff    <= cwnd_in;
            ss_ff      <= ss_in;
            inf_ff     <= inf_in;
            avoid_ff   <= avoid_in;
            rtime_ff   <= rtime_in;
            rseq_ff    <= rseq_in;
            resid_ff   <= resid_in;
            entered_ff <= entered_in;
         end
         if (cmd.set_residue) begin
            resid_ff <= div_rem[61:0];
         end
         if (cmd.apply_avoid) begin
            cwnd_ff <= avoid_cwnd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= opcode_type'(req_opcode);
         bytes_ff <= req_byte_count;
         now_ff   <= req_now_time;
         srtt_ff  <= req_smoothed_rtt;
         next_ff  <= req_next_send_sequence;
         aseq_ff  <= req_highest_acked_sequence;
         atime_ff <= req_acked_send_time;
         hist_ff  <= req_history_empty;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.acc_sel)
         ACC_DELTA:  delta_ff <= prod_ff[62:0] + {1'b0, resid_ff};
         ACC_NUM_LO: num_ff   <= {32'b0, prod_ff};
         ACC_NUM_HI: num_ff   <= num_ff + {prod_ff, 32'b0};
         ACC_DEN_LO: den_ff   <= {32'b0, prod_ff};
         ACC_DEN_HI: den_ff   <= den_ff + {prod_ff, 32'b0};
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_window_ff    <= cwnd_ff;
         rsp_threshold_ff <= inf_ff ? '0 : ss_ff;
         rsp_mode_ff      <= avoid_ff;
         rsp_entered_ff   <= entered_ff;
      end
   end

   always_comb begin
      case (cfg_index)
         REG_INITIAL:   cfg_rdata = init_ff;
         REG_MINIMUM:   cfg_rdata = minw_ff;
         REG_SEGMENT:   cfg_rdata = {16'b0, seg_ff};
         REG_INTERVAL:  cfg_rdata = ivl_ff;
         REG_MULTIPATH: cfg_rdata = {31'b0, mp_ff};
         default:       cfg_rdata = '0;
      endcase
   end

   assign status.long_ack = (op_ff == OP_ACK) && avoid_ff;
   assign status.div_busy = div_busy;

   assign rsp_window           = rsp_window_ff;
   assign rsp_threshold        = rsp_threshold_ff;
   assign rsp_mode             = rsp_mode_ff;
   assign rsp_entered_recovery = rsp_entered_ff;

endmodule

/* src/nrcw_controller.sv */
// Controller state machine: sequences capture, update, multiplies and divisions,
// and owns the input stall and result valid. Depends on nrcw_pkg.
module nrcw_controller import nrcw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DELTA,
      ST_MODSTART,
      ST_NUM0,
      ST_NUM1,
      ST_DEN0,
      ST_DEN1,
      ST_MODWAIT,
      ST_QUOWAIT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_BYTES_SEG;
      cmd.acc_sel = ACC_NONE;
      cmd.div_sel = DIV_MOD;
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.long_ack) begin
               cmd.mul_en = 1'b1;
               state_in   = ST_DELTA;
            end else begin
               cmd.eval = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_DELTA: begin
            cmd.acc_sel = ACC_DELTA;
            state_in    = ST_MODSTART;
         end
         ST_MODSTART: begin
            // The residue division runs while the products are formed.
            cmd.div_start = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_R_DL;
            state_in      = ST_NUM0;
         end
         ST_NUM0: begin
            cmd.acc_sel = ACC_NUM_LO;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_R_DH;
            state_in    = ST_NUM1;
         end
         ST_NUM1: begin
            cmd.acc_sel = ACC_NUM_HI;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_IVL_WL;
            state_in    = ST_DEN0;
         end
         ST_DEN0: begin
            cmd.acc_sel = ACC_DEN_LO;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_IVL_WH;
            state_in    = ST_DEN1;
         end
         ST_DEN1: begin
            cmd.acc_sel = ACC_DEN_HI;
            state_in    = ST_MODWAIT;
         end
         ST_MODWAIT: begin
            if (!status.div_busy) begin
               cmd.set_residue = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_sel     = DIV_QUO;
               state_in        = ST_QUOWAIT;
            end
         end
         ST_QUOWAIT: begin
            if (!status.div_busy) begin
               cmd.apply_avoid = 1'b1;
               state_in        = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/new_reno_congestion_window.sv */
// New Reno congestion window controller, top level.
// One event beat enters on the req_ channel; exactly one result beat leaves on
// the rsp_ channel with the window, threshold, mode and recovery flag after it.
// A beat is accepted at a clock edge with valid high and stall low.
// Events other than a congestion-avoidance ack pass through capture, the
// update and the load of the result register, which waits for a free output.
// An ack in congestion avoidance goes a longer way: a 32x32 multiplier
// forms the products, overlapped with a residue division, followed by a
// quotient division in the same shared bit-serial divider.
// The block holds one event at a time; req_stall is high while it works.
// A new event may be accepted while the previous result waits under rsp_stall;
// its result is held back until the output register is free.
// Configuration must be written through the APB-style port only while idle; the block does not enforce this.
// Synchronous reset restores the register defaults and the slow-start state,
// and leaves the result channel empty; no clearing pass is needed.
// Depends on nrcw_pkg, nrcw_controller, nrcw_datapath and the defines header.
`include "new_reno_congestion_window_defines.svh"

module new_reno_congestion_window import nrcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_byte_count,
   input  logic [62:0] req_now_time,
   input  logic [31:0] req_smoothed_rtt,
   input  logic [62:0] req_next_send_sequence,
   input  logic [62:0] req_highest_acked_sequence,
   input  logic [62:0] req_acked_send_time,
   input  logic        req_history_empty,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [61:0] rsp_window,
   output logic [61:0] rsp_threshold,
   output logic        rsp_mode,
   output logic        rsp_entered_recovery,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   nrcw_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nrcw_datapath u_dp (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .status                     (status),
      .cfg_we                     (cfg_we),
      .cfg_index                  (paddr[4:2]),
      .cfg_data                   (pwdata),
      .cfg_rdata                  (prdata),
      .req_opcode                 (req_opcode),
      .req_byte_count             (req_byte_count),
      .req_now_time               (req_now_time),
      .req_smoothed_rtt           (req_smoothed_rtt),
      .req_next_send_sequence     (req_next_send_sequence),
      .req_highest_acked_sequence (req_highest_acked_sequence),
      .req_acked_send_time        (req_acked_send_time),
      .req_history_empty          (req_history_empty),
      .rsp_window                 (rsp_window),
      .rsp_threshold              (rsp_threshold),
      .rsp_mode                   (rsp_mode),
      .rsp_entered_recovery       (rsp_entered_recovery)
   );

   // An accepted event keeps the block busy in the following cycle.
   `NRCW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "double accept")
   // A new result only appears while an event is being worked on.
   `NRCW_ASSERT_SAME(a_result_from_work, $rose(rsp_valid), $past(req_stall), "result while idle")

endmodule
